// ----- hw/rtl/lsa_pkg.sv -----
// Leased slot allocator: shared field widths, request and status codes, control types.
package lsa_pkg;

	localparam int KIND_W     = 3;
	localparam int SLOT_W     = 16;
	localparam int CTX_W      = 64;
	localparam int READERS_W  = 16;
	localparam int COUNT_W    = 17;
	localparam int CAP_W      = 17;
	localparam int STATUS_W   = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

	localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RECYCLE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DETACH  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DETACHED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic capture;	// request accepted: latch it and issue table reads
		logic commit;	// write tables back and load the result register
	} lsa_cmd_t;

endpackage

// ----- hw/rtl/lsa_if.sv -----
// Request and result channel interfaces of the leased slot allocator.
interface lsa_req_if;
	import lsa_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   slot_index;
	logic [CTX_W-1:0]    context_value;

	modport source (output valid, output kind, output slot_index, output context_value,
		input ready);
	modport sink (input valid, input kind, input slot_index, input context_value,
		output ready);
endinterface

interface lsa_rsp_if;
	import lsa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_W-1:0]    slot_out;
	logic [CTX_W-1:0]     context_out;
	logic [READERS_W-1:0] readers_out;
	logic                 detached_out;
	logic [COUNT_W-1:0]   in_use_count;

	modport source (output valid, output status, output slot_out, output context_out,
		output readers_out, output detached_out, output in_use_count, input ready);
	modport sink (input valid, input status, input slot_out, input context_out,
		input readers_out, input detached_out, input in_use_count, output ready);
endinterface

// ----- hw/rtl/leased_slot_allocator.sv -----
// Leased slot allocator top level.
// The request is latched on accept; the result register is loaded at commit in the execute state,
// which waits while an old result is held. A new request is not taken until the previous one commits;
// the slot table and free stack are read on accept and written back at commit.
// A stalled result holds the next request in execution until the result is taken.
// Reset clears counters, capacity (to 65536) and handshake state; no table sweep is needed.
module leased_slot_allocator #(
	parameter int SLOTS       = 65536,
	parameter int READER_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [lsa_pkg::CAP_W-1:0] cfg_wr_data,
	lsa_req_if.sink                   req,
	lsa_rsp_if.source                 rsp
);
	import lsa_pkg::*;

	lsa_cmd_t cmd;

	lsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	lsa_datapath #(
		.SLOTS       (SLOTS),
		.READER_BITS (READER_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.kind          (req.kind),
		.slot_index    (req.slot_index),
		.context_value (req.context_value),
		.status        (rsp.status),
		.slot_out      (rsp.slot_out),
		.context_out   (rsp.context_out),
		.readers_out   (rsp.readers_out),
		.detached_out  (rsp.detached_out),
		.in_use_count  (rsp.in_use_count)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture and commit in the same cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !req.ready)
		else $error("request taken while previous one still executing");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("result shown without a commit");

endmodule

// ----- hw/rtl/lsa_ctrl.sv -----
// Leased slot allocator controller: request sequencing and result register handshake.
module lsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lsa_pkg::lsa_cmd_t cmd
);
	import lsa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	// result register is free, or being drained this cycle
	assign cmd.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.commit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/lsa_datapath.sv -----
// Leased slot allocator datapath: slot table, free stack, counters and result register.
module lsa_datapath #(
	parameter int SLOTS       = 65536,
	parameter int READER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lsa_pkg::lsa_cmd_t             cmd,
	input  logic                          cfg_wr_en,
	input  logic [lsa_pkg::CAP_W-1:0]     cfg_wr_data,
	input  logic [lsa_pkg::KIND_W-1:0]    kind,
	input  logic [lsa_pkg::SLOT_W-1:0]    slot_index,
	input  logic [lsa_pkg::CTX_W-1:0]     context_value,
	output logic [lsa_pkg::STATUS_W-1:0]  status,
	output logic [lsa_pkg::SLOT_W-1:0]    slot_out,
	output logic [lsa_pkg::CTX_W-1:0]     context_out,
	output logic [lsa_pkg::READERS_W-1:0] readers_out,
	output logic                          detached_out,
	output logic [lsa_pkg::COUNT_W-1:0]   in_use_count
);
	import lsa_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [CAP_W-1:0] SLOTS_CAP = CAP_W'(SLOTS);

	typedef struct packed {
		logic                   alloc;
		logic                   det;
		logic [READER_BITS-1:0] readers;
		logic [CTX_W-1:0]       ctx;
	} entry_t;

	entry_t        ent_mem [SLOTS];
	logic [IW-1:0] stack_mem [SLOTS];

	logic [CAP_W-1:0]  cap_q;
	logic [CW-1:0]     free_depth_q;
	logic [CW-1:0]     next_fresh_q;
	logic [CW-1:0]     in_use_q;

	logic [KIND_W-1:0] kind_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CTX_W-1:0]  ctx_q;
	entry_t            ent_rd_q;
	logic [IW-1:0]     stack_rd_q;

	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CTX_W-1:0]     ctx_out_q;
	logic [READERS_W-1:0] readers_q;
	logic                 det_q;
	logic [COUNT_W-1:0]   count_q;

	logic [CW-1:0]      depth_m1;
	logic [CAP_W-1:0]   cap_eff;
	logic               fresh_ok;
	logic               hit;
	logic [STATUS_W-1:0] status_d;
	logic [SLOT_W-1:0]  slot_d;
	logic [CTX_W-1:0]   ctx_d;
	entry_t             ent_d;
	logic [IW-1:0]      ent_addr;
	logic               ent_wr;
	logic               push;
	logic               pop;
	logic               fresh;
	logic               inc;
	logic               dec;
	logic               shown;
	logic [CW-1:0]      in_use_nx;

	assign depth_m1 = free_depth_q - CW'(1);
	assign cap_eff  = (cap_q < SLOTS_CAP) ? cap_q : SLOTS_CAP;
	assign fresh_ok = CAP_W'(next_fresh_q) < cap_eff;
	// slots at or above next_fresh were never handed out, so their table entries are stale
	assign hit = (CAP_W'(idx_q) < SLOTS_CAP) && (CAP_W'(idx_q) < CAP_W'(next_fresh_q))
		&& ent_rd_q.alloc;

	always_comb begin
		status_d = ST_OK;
		slot_d   = idx_q;
		ctx_d    = '0;
		ent_d    = ent_rd_q;
		ent_addr = idx_q[IW-1:0];
		ent_wr   = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		fresh    = 1'b0;
		inc      = 1'b0;
		dec      = 1'b0;
		shown    = hit;
		if (kind_q == KIND_CREATE) begin
			shown = 1'b0;
			if (free_depth_q != '0) begin
				pop      = 1'b1;
				ent_addr = stack_rd_q;
			end else if (fresh_ok) begin
				fresh    = 1'b1;
				ent_addr = next_fresh_q[IW-1:0];
			end
			if (pop || fresh) begin
				ent_wr        = 1'b1;
				inc           = 1'b1;
				shown         = 1'b1;
				ent_d.alloc   = 1'b1;
				ent_d.det     = 1'b0;
				ent_d.readers = '0;
				ent_d.ctx     = ctx_q;
				slot_d        = SLOT_W'(ent_addr);
			end else begin
				status_d = ST_FULL;
				slot_d   = '0;
			end
		end else if (!hit) begin
			status_d = ST_BAD_SLOT;
		end else begin
			unique case (kind_q)
				KIND_RECYCLE: begin
					if (!ent_rd_q.det || ent_rd_q.readers != '0) begin
						status_d = ST_BUSY;
					end else begin
						ent_d.alloc = 1'b0;
						ent_wr      = 1'b1;
						push        = 1'b1;
						dec         = 1'b1;
					end
				end
				KIND_ACQUIRE: begin
					if (ent_rd_q.det) begin
						status_d = ST_DETACHED;
					end else if (ent_rd_q.readers == '1) begin
						status_d = ST_SATURATED;
					end else begin
						ent_d.readers = ent_rd_q.readers + READER_BITS'(1);
						ent_wr        = 1'b1;
						ctx_d         = ent_rd_q.ctx;
					end
				end
				KIND_RELEASE: begin
					if (ent_rd_q.readers == '0) begin
						status_d = ST_UNDERFLOW;
					end else begin
						ent_d.readers = ent_rd_q.readers - READER_BITS'(1);
						ent_wr        = 1'b1;
					end
				end
				KIND_DETACH: begin
					ent_d.det = 1'b1;
					ent_wr    = 1'b1;
				end
				default: begin
					// query and unused codes leave the slot as it is
				end
			endcase
		end
		if (inc) in_use_nx = in_use_q + CW'(1);
		else if (dec) in_use_nx = in_use_q - CW'(1);
		else in_use_nx = in_use_q;
	end

	// slot table: one read at request capture, one write at commit
	always_ff @(posedge clk) begin
		if (cmd.commit && ent_wr) ent_mem[ent_addr] <= ent_d;
		if (cmd.capture) ent_rd_q <= ent_mem[slot_index[IW-1:0]];
	end

	// free stack: top read at capture, push at commit
	always_ff @(posedge clk) begin
		if (cmd.commit && push) stack_mem[free_depth_q[IW-1:0]] <= idx_q[IW-1:0];
		if (cmd.capture) stack_rd_q <= stack_mem[depth_m1[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			idx_q  <= slot_index;
			ctx_q  <= context_value;
		end
		if (cmd.commit) begin
			status_q  <= status_d;
			slot_q    <= slot_d;
			ctx_out_q <= ctx_d;
			readers_q <= (shown && ent_d.alloc) ? READERS_W'(ent_d.readers) : '0;
			det_q     <= shown && ent_d.alloc && ent_d.det;
			count_q   <= COUNT_W'(in_use_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			free_depth_q <= '0;
			next_fresh_q <= '0;
			in_use_q     <= '0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (cmd.commit) begin
				if (pop) free_depth_q <= depth_m1;
				else if (push) free_depth_q <= free_depth_q + CW'(1);
				if (fresh) next_fresh_q <= next_fresh_q + CW'(1);
				in_use_q <= in_use_nx;
			end
		end
	end

	assign status       = status_q;
	assign slot_out     = slot_q;
	assign context_out  = ctx_out_q;
	assign readers_out  = readers_q;
	assign detached_out = det_q;
	assign in_use_count = count_q;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the leased slot allocator: directed lease cases, random traffic, table fill.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lsa_pkg::*;

	localparam logic [KIND_W-1:0]    KIND_SPARE_A  = 3'd6;
	localparam logic [KIND_W-1:0]    KIND_SPARE_B  = 3'd7;
	localparam int                   TABLE_SLOTS   = 65536;
	localparam logic [READERS_W-1:0] READER_LIMIT = '1;
	localparam int                   QUIET_LIMIT   = 4000;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot;
		logic [CTX_W-1:0]     ctx;
		logic [READERS_W-1:0] readers;
		logic                 det;
		logic [COUNT_W-1:0]   in_use;
	} lease_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CAP_W-1:0]    cfg_wr_data;

	lsa_req_if req_bus ();
	lsa_rsp_if rsp_bus ();

	leased_slot_allocator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_bus),
		.rsp         (rsp_bus)
	);

	always #5 clk = ~clk;

	// lease table mirror
	logic [SLOT_W-1:0]    free_slots [0:TABLE_SLOTS-1];
	int                   free_top;
	int                   fresh_next;
	int                   leased_total;
	bit                   leased     [0:TABLE_SLOTS-1];
	logic [READERS_W-1:0] readers    [0:TABLE_SLOTS-1];
	bit                   detached   [0:TABLE_SLOTS-1];
	logic [CTX_W-1:0]     lease_ctx  [0:TABLE_SLOTS-1];
	logic [CAP_W-1:0]     capacity;
	logic [SLOT_W-1:0]    live_slots [$];

	lease_result_t pending_results [$];
	lease_result_t last_result;
	int            requests_sent;
	int            mismatches;
	bit            idle_on;
	bit            hold_off_pending;
	int            hold_off_len;
	int            quiet_cycles;

	function automatic lease_result_t apply_request(input logic [KIND_W-1:0] k,
			input logic [SLOT_W-1:0] idx, input logic [CTX_W-1:0] ctx);
		lease_result_t r;
		logic [SLOT_W-1:0] s;
		bit got;
		int cap_eff;
		r = '0;
		r.status = ST_OK;
		s = idx;
		got = 1'b0;
		cap_eff = (capacity > TABLE_SLOTS) ? TABLE_SLOTS : int'(capacity);
		if (k == KIND_CREATE) begin
			if (free_top > 0) begin
				free_top--;
				s = free_slots[free_top];
				got = 1'b1;
			end else if (fresh_next < cap_eff) begin
				s = fresh_next[SLOT_W-1:0];
				fresh_next++;
				got = 1'b1;
			end else begin
				r.status = ST_FULL;
				s = '0;
			end
			if (got) begin
				leased[s] = 1'b1;
				readers[s] = '0;
				detached[s] = 1'b0;
				lease_ctx[s] = ctx;
				leased_total++;
				live_slots = {live_slots, s};
			end
		end else if (!leased[idx]) begin
			r.status = ST_BAD_SLOT;
		end else if (k == KIND_RECYCLE) begin
			if (!detached[idx] || readers[idx] != 0) begin
				r.status = ST_BUSY;
			end else begin
				leased[idx] = 1'b0;
				free_slots[free_top] = idx;
				free_top++;
				leased_total--;
				foreach (live_slots[i]) if (live_slots[i] == idx) begin
					live_slots.delete(i);
					break;
				end
			end
		end else if (k == KIND_ACQUIRE) begin
			if (detached[idx]) r.status = ST_DETACHED;
			else if (readers[idx] == READER_LIMIT) r.status = ST_SATURATED;
			else begin
				readers[idx]++;
				r.ctx = lease_ctx[idx];
			end
		end else if (k == KIND_RELEASE) begin
			if (readers[idx] == 0) r.status = ST_UNDERFLOW;
			else readers[idx]--;
		end else if (k == KIND_DETACH) begin
			detached[idx] = 1'b1;
		end
		r.slot = s;
		if (leased[s] && r.status != ST_FULL) begin
			r.readers = readers[s];
			r.det = detached[s];
		end
		r.in_use = leased_total[COUNT_W-1:0];
		return r;
	endfunction

	task automatic send_request(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] idx,
			input logic [CTX_W-1:0] ctx);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.kind <= k;
		req_bus.slot_index <= idx;
		req_bus.context_value <= ctx;
		do @(posedge clk); while (!req_bus.ready);
		last_result = apply_request(k, idx, ctx);
		pending_results = {pending_results, last_result};
		requests_sent++;
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity = value;
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot();
		if (live_slots.size() != 0 && $urandom_range(0, 9) < 8)
			return live_slots[$urandom_range(0, live_slots.size() - 1)];
		return SLOT_W'($urandom);
	endfunction

	task automatic random_request();
		int pick;
		logic [KIND_W-1:0] k;
		pick = $urandom_range(0, 99);
		if (pick < 18) k = KIND_CREATE;
		else if (pick < 34) k = KIND_ACQUIRE;
		else if (pick < 50) k = KIND_RELEASE;
		else if (pick < 62) k = KIND_DETACH;
		else if (pick < 76) k = KIND_RECYCLE;
		else if (pick < 88) k = KIND_QUERY;
		else if (pick < 94) k = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
		else k = KIND_W'($urandom);
		send_request(k, pick_slot(), {$urandom, $urandom});
	endtask

	// create, take and drop readers, detach, then usually hand the slot back
	task automatic lease_lifecycle();
		int n;
		logic [SLOT_W-1:0] s;
		send_request(KIND_CREATE, SLOT_W'($urandom), {$urandom, $urandom});
		if (last_result.status != ST_OK) return;
		s = last_result.slot;
		n = $urandom_range(0, 4);
		repeat (n) send_request(KIND_ACQUIRE, s, {$urandom, $urandom});
		if ($urandom_range(0, 3) == 0) send_request(KIND_RECYCLE, s, {$urandom, $urandom});
		repeat (n) send_request(KIND_RELEASE, s, {$urandom, $urandom});
		send_request(KIND_DETACH, s, {$urandom, $urandom});
		if ($urandom_range(0, 2) == 0) send_request(KIND_ACQUIRE, s, {$urandom, $urandom});
		if ($urandom_range(0, 2) == 0) send_request(KIND_RELEASE, s, {$urandom, $urandom});
		if ($urandom_range(0, 3) != 0) send_request(KIND_RECYCLE, s, {$urandom, $urandom});
	endtask

	task automatic test_basic_ops();
		send_request(KIND_QUERY, 16'h0000, '0);
		send_request(KIND_CREATE, 16'hFFFF, '1);
		send_request(KIND_CREATE, 16'h0000, '0);
		send_request(KIND_CREATE, 16'h5555, {$urandom, $urandom});
		send_request(KIND_ACQUIRE, 16'h0000, '0);
		send_request(KIND_ACQUIRE, 16'h0001, '1);
		send_request(KIND_QUERY, 16'h0000, '0);
		send_request(KIND_SPARE_A, 16'h0000, '0);
		send_request(KIND_SPARE_B, 16'h0001, '0);
		send_request(KIND_RELEASE, 16'h0000, '0);
		send_request(KIND_RELEASE, 16'h0000, '0);
		send_request(KIND_RECYCLE, 16'h0001, '0);
		send_request(KIND_DETACH, 16'h0001, '0);
		send_request(KIND_RECYCLE, 16'h0001, '0);
		send_request(KIND_ACQUIRE, 16'h0001, '0);
		send_request(KIND_RELEASE, 16'h0001, '0);
		send_request(KIND_DETACH, 16'h0001, '0);
		send_request(KIND_RECYCLE, 16'h0001, '0);
		send_request(KIND_QUERY, 16'h0001, '0);
		send_request(KIND_ACQUIRE, 16'hFFFF, '0);
		send_request(KIND_DETACH, 16'h0002, '0);
		send_request(KIND_RECYCLE, 16'h0002, '0);
		// stack is last in, first out: slot 2 comes back before slot 1
		send_request(KIND_CREATE, 16'h0000, 64'hA5A5_5A5A_F0F0_0F0F);
		send_request(KIND_CREATE, 16'h0000, 64'h0123_4567_89AB_CDEF);
		send_request(KIND_RELEASE, 16'h8000, '0);
	endtask

	task automatic test_capacity_limits();
		// capacity below the slots already handed out
		write_capacity(17'd1);
		send_request(KIND_CREATE, '0, {$urandom, $urandom});
		send_request(KIND_DETACH, 16'h0000, '0);
		send_request(KIND_RECYCLE, 16'h0000, '0);
		send_request(KIND_CREATE, '0, {$urandom, $urandom});
		send_request(KIND_CREATE, '0, {$urandom, $urandom});
		write_capacity(17'd4);
		send_request(KIND_CREATE, '0, {$urandom, $urandom});
		send_request(KIND_CREATE, '0, {$urandom, $urandom});
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [6];
		int target;
		caps = '{17'd6, 17'd1, CAP_RESET, CAP_W'($urandom_range(2, 48)), 17'd2, 17'd20};
		foreach (caps[p]) begin
			write_capacity(caps[p]);
			target = requests_sent + 245;
			while (requests_sent < target) begin
				if ($urandom_range(0, 2) == 0) lease_lifecycle();
				else random_request();
			end
		end
	endtask

	task automatic test_backpressure();
		hold_off_len = 400;
		hold_off_pending = 1'b1;
		repeat (40) random_request();
		wait_drained();
		repeat (30) random_request();
		wait_drained();
	endtask

	task automatic test_reader_counts();
		logic [SLOT_W-1:0] s;
		write_capacity(CAP_RESET);
		send_request(KIND_CREATE, '0, {$urandom, $urandom});
		s = last_result.slot;
		repeat (3) send_request(KIND_ACQUIRE, s, '0);
		repeat (3) send_request(KIND_RELEASE, s, '0);
		send_request(KIND_RELEASE, s, '0);
		send_request(KIND_ACQUIRE, s, '0);
		send_request(KIND_RECYCLE, s, '0);
		send_request(KIND_DETACH, s, '0);
		send_request(KIND_ACQUIRE, s, '0);
		send_request(KIND_RECYCLE, s, '0);
		send_request(KIND_RELEASE, s, '0);
		send_request(KIND_RECYCLE, s, '0);
		send_request(KIND_QUERY, s, '0);
	endtask

	task automatic test_fill_table();
		write_capacity(17'd96);
		do send_request(KIND_CREATE, SLOT_W'($urandom), {$urandom, $urandom});
		while (last_result.status != ST_FULL);
		send_request(KIND_QUERY, 16'hFFFF, '0);
		send_request(KIND_ACQUIRE, 16'hFFFF, '0);
		send_request(KIND_RELEASE, 16'hFFFF, '0);
		send_request(KIND_DETACH, 16'hFFFF, '0);
		send_request(KIND_RECYCLE, 16'hFFFF, '0);
		send_request(KIND_CREATE, '0, '1);
		send_request(KIND_CREATE, '0, '1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req_bus.valid <= 1'b0;
		req_bus.kind <= KIND_QUERY;
		req_bus.slot_index <= '0;
		req_bus.context_value <= '0;
		free_top = 0;
		fresh_next = 0;
		leased_total = 0;
		capacity = CAP_RESET;
		requests_sent = 0;
		mismatches = 0;
		idle_on = 1'b1;
		hold_off_pending = 1'b0;
		hold_off_len = 0;
		foreach (leased[i]) begin
			leased[i] = 1'b0;
			readers[i] = '0;
			detached[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_capacity_limits();
		test_random_traffic();
		test_backpressure();
		idle_on = 1'b0;
		test_reader_counts();
		test_fill_table();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on demand
	initial begin : result_receiver
		rsp_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				rsp_bus.ready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				rsp_bus.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic compare_field(input string name, input logic [CTX_W-1:0] want,
			input logic [CTX_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		lease_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request pending, expected none, actual status %0h",
					$time, rsp_bus.status);
			end else begin
				want = pending_results.pop_front();
				compare_field("status", CTX_W'(want.status), CTX_W'(rsp_bus.status));
				compare_field("slot_out", CTX_W'(want.slot), CTX_W'(rsp_bus.slot_out));
				compare_field("context_out", want.ctx, rsp_bus.context_out);
				compare_field("readers_out", CTX_W'(want.readers),
					CTX_W'(rsp_bus.readers_out));
				compare_field("detached_out", CTX_W'(want.det), CTX_W'(rsp_bus.detached_out));
				compare_field("in_use_count", CTX_W'(want.in_use),
					CTX_W'(rsp_bus.in_use_count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ----- leased_slot_allocator.f -----
hw/rtl/lsa_pkg.sv
hw/rtl/lsa_if.sv
hw/rtl/lsa_ctrl.sv
hw/rtl/lsa_datapath.sv
hw/rtl/leased_slot_allocator.sv
bench/tb_top.sv
